// File: hw/rtl/heap_chunk_safety_monitor_core_defines.svh
// Assertion macros for the heap chunk safety monitor RTL.
`ifndef HEAP_CHUNK_SAFETY_MONITOR_CORE_DEFINES_SVH
`define HEAP_CHUNK_SAFETY_MONITOR_CORE_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define HCSM_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define HCSM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/hcsm_pkg.sv
// Types and constants shared by the heap chunk safety monitor.
package hcsm_pkg;

    localparam int ACTION_W = 3;
    localparam int SIZE_W   = 32;
    localparam int MARGIN_W = 8;
    localparam int REPORT_W = 4;
    localparam int CFG_IDX_W = 2;

    localparam logic [ACTION_W-1:0] ACT_ALLOC  = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_FREE   = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_CHECK  = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_ACCESS = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_LEAK   = 3'd4;

    localparam logic [REPORT_W-1:0] RPT_NONE           = 4'd0;
    localparam logic [REPORT_W-1:0] RPT_ZERO_SIZE      = 4'd1;
    localparam logic [REPORT_W-1:0] RPT_ALLOC_NULL     = 4'd2;
    localparam logic [REPORT_W-1:0] RPT_DOUBLE_FREE    = 4'd3;
    localparam logic [REPORT_W-1:0] RPT_OOB            = 4'd4;
    localparam logic [REPORT_W-1:0] RPT_UAF            = 4'd5;
    localparam logic [REPORT_W-1:0] RPT_UNCHECKED      = 4'd6;
    localparam logic [REPORT_W-1:0] RPT_LEAK_UNCHECKED = 4'd7;
    localparam logic [REPORT_W-1:0] RPT_LEAK           = 4'd8;
    localparam logic [REPORT_W-1:0] RPT_TABLE_FULL     = 4'd9;

    localparam logic [CFG_IDX_W-1:0] CFG_WATCH_LOW  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WATCH_HIGH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MARGIN     = 2'd2;

    localparam logic [MARGIN_W-1:0] MARGIN_RESET = 8'd4;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ZERO,
        ST_PRE,
        ST_WALK,
        ST_TAIL,
        ST_FLUSH
    } t_state;

    typedef struct packed {
        logic eq;
        logic covered;
        logic redzone;
    } t_match;

endpackage

// File: hw/rtl/hcsm_in_if.sv
// Input channel carrying one monitor event per word.
interface hcsm_in_if #(
    parameter int ADDR_BITS = 48
);
    import hcsm_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [ACTION_W-1:0]  action;
    logic [ADDR_BITS-1:0] address;
    logic [SIZE_W-1:0]    size;
    logic [ADDR_BITS-1:0] pc;

    modport source (output valid, action, address, size, pc, input ready);
    modport sink (input valid, action, address, size, pc, output ready);

endinterface

// File: hw/rtl/hcsm_out_if.sv
// Output channel carrying one monitor report per word.
interface hcsm_out_if #(
    parameter int ADDR_BITS = 48
);
    import hcsm_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [REPORT_W-1:0]  report;
    logic [ADDR_BITS-1:0] chunk_base;
    logic                 last;

    modport source (output valid, report, chunk_base, last, input ready);
    modport sink (input valid, report, chunk_base, last, output ready);

endinterface

// File: hw/rtl/hcsm_table.sv
// Chunk table memory with one write port and one registered read port.
module hcsm_table #(
    parameter int DEPTH = 32,
    parameter int WIDTH = 82,
    parameter int IDX_W = 5
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [IDX_W-1:0] i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [IDX_W-1:0] i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: hw/rtl/hcsm_match.sv
// Shared compare unit: base match, chunk containment and redzone hit for one entry.
module hcsm_match #(
    parameter int ADDR_BITS = 48
) (
    input  logic [ADDR_BITS-1:0]         i_addr,
    input  logic [ADDR_BITS-1:0]         i_base,
    input  logic [hcsm_pkg::SIZE_W-1:0]  i_len,
    input  logic [hcsm_pkg::MARGIN_W-1:0] i_margin,
    output hcsm_pkg::t_match             o_match
);
    import hcsm_pkg::*;

    localparam int EXT_W = ((ADDR_BITS > SIZE_W) ? ADDR_BITS : SIZE_W) + 1;

    logic                 below;
    logic [ADDR_BITS-1:0] diff_up;
    logic [ADDR_BITS-1:0] diff_dn;
    logic [EXT_W-1:0]     diff_up_x;
    logic [EXT_W-1:0]     len_x;
    logic [EXT_W-1:0]     over;
    logic [EXT_W-1:0]     margin_x;
    logic                 inside_hit;

    assign below      = i_addr < i_base;
    assign diff_up    = i_addr - i_base;
    assign diff_dn    = i_base - i_addr;
    assign diff_up_x  = {{(EXT_W-ADDR_BITS){1'b0}}, diff_up};
    assign len_x      = {{(EXT_W-SIZE_W){1'b0}}, i_len};
    assign margin_x   = {{(EXT_W-MARGIN_W){1'b0}}, i_margin};
    assign over       = diff_up_x - len_x;
    assign inside_hit = !below && (diff_up_x <= len_x);

    always_comb begin
        o_match.eq      = (i_addr == i_base);
        o_match.covered = inside_hit;
        if (below) begin
            o_match.redzone = ({{(EXT_W-ADDR_BITS){1'b0}}, diff_dn} <= margin_x);
        end else begin
            o_match.redzone = !inside_hit && (over <= margin_x);
        end
    end

endmodule

// File: hw/rtl/heap_chunk_safety_monitor_core.sv
// Heap chunk safety monitor top level: sequencer, configuration and output register.
//
// Events arrive on i_in (action, address, size, pc) and reports leave on o_out
// (report, chunk_base, last). Each accepted word yields one or more report words;
// last is set on the final one, and an event with nothing to report gives a single
// report of none. Configuration is written through i_cfg_we, i_cfg_index and
// i_cfg_data; the user must do so only while the block is idle, which the block
// itself does not enforce. One event is handled at a time. The table is walked
// from the newest entry toward the oldest, one entry per cycle while no report
// stalls, through the single read port of the chunk memory and the shared compare
// unit. After the walk the sequencer passes the tail and flush states, and the
// final report is registered into the output register from the flush state.
// Each report is held back by one word so that last can be set on the true final
// one; when the receiver stalls the walk pauses on the entry that must report.
// Reset clears the chunk count, the sequencer and the output register, and sets
// the watch range to zero and the redzone margin to four bytes; the chunk memory
// itself is not cleared, as entries at or above the count are never read.
`include "heap_chunk_safety_monitor_core_defines.svh"

module heap_chunk_safety_monitor_core #(
    parameter int MAX_CHUNKS = 32,
    parameter int ADDR_BITS  = 48
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [hcsm_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [ADDR_BITS-1:0]           i_cfg_data,
    hcsm_in_if.sink                        i_in,
    hcsm_out_if.source                     o_out
);
    import hcsm_pkg::*;

    localparam int IDX_W = (MAX_CHUNKS > 1) ? $clog2(MAX_CHUNKS) : 1;
    localparam int CNT_W = $clog2(MAX_CHUNKS + 1);
    localparam int ENT_W = ADDR_BITS + SIZE_W + 2;
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_CHUNKS);

    t_state                r_state, n_state;
    logic [ADDR_BITS-1:0]  r_watch_lo;
    logic [ADDR_BITS-1:0]  r_watch_hi;
    logic [MARGIN_W-1:0]   r_margin;

    logic [ACTION_W-1:0]   r_action;
    logic [ADDR_BITS-1:0]  r_addr;
    logic [SIZE_W-1:0]     r_size;
    logic                  r_watched;

    logic [CNT_W-1:0]      r_count, n_count;
    logic [IDX_W-1:0]      r_idx, n_idx;
    logic                  r_found, n_found;
    logic                  r_fault_v, n_fault_v;
    logic [REPORT_W-1:0]   r_fault_rpt, n_fault_rpt;
    logic [ADDR_BITS-1:0]  r_fault_base, n_fault_base;
    logic                  r_pend_v, n_pend_v;
    logic [REPORT_W-1:0]   r_pend_rpt, n_pend_rpt;
    logic [ADDR_BITS-1:0]  r_pend_base, n_pend_base;

    logic                  r_out_v;
    logic [REPORT_W-1:0]   r_out_rpt;
    logic [ADDR_BITS-1:0]  r_out_base;
    logic                  r_out_last;

    logic                  in_acc;
    logic                  out_free;
    logic                  can_emit;
    logic [CNT_W-1:0]      cnt_m1;

    logic                  rd_en;
    logic [IDX_W-1:0]      rd_idx;
    logic [ENT_W-1:0]      rd_data;
    logic                  wr_en;
    logic [IDX_W-1:0]      wr_idx;
    logic [ADDR_BITS-1:0]  wr_start;
    logic [SIZE_W-1:0]     wr_len;
    logic                  wr_live;
    logic                  wr_chk;
    logic [ENT_W-1:0]      wr_data;

    logic [ADDR_BITS-1:0]  e_start;
    logic [SIZE_W-1:0]     e_len;
    logic                  e_live;
    logic                  e_chk;
    t_match                mt;

    logic                  walk_emit;
    logic [REPORT_W-1:0]   walk_rpt;
    logic                  walk_wr;
    logic [SIZE_W-1:0]     walk_len;
    logic                  walk_live;
    logic                  walk_chk;
    logic                  walk_brk;
    logic                  walk_hit;
    logic                  walk_fault;
    logic [REPORT_W-1:0]   walk_fault_rpt;

    logic                  emit_req;
    logic [REPORT_W-1:0]   emit_rpt;
    logic [ADDR_BITS-1:0]  emit_base;
    logic                  flush;
    logic                  push;
    logic [REPORT_W-1:0]   push_rpt;
    logic [ADDR_BITS-1:0]  push_base;
    logic                  push_last;

    assign in_acc   = i_in.valid && i_in.ready;
    assign out_free = !r_out_v || o_out.ready;
    assign can_emit = !r_pend_v || out_free;
    assign cnt_m1   = r_count - 1'b1;

    assign i_in.ready       = (r_state == ST_IDLE);
    assign o_out.valid      = r_out_v;
    assign o_out.report     = r_out_rpt;
    assign o_out.chunk_base = r_out_base;
    assign o_out.last       = r_out_last;

    assign e_start = rd_data[ENT_W-1 -: ADDR_BITS];
    assign e_len   = rd_data[SIZE_W+1 -: SIZE_W];
    assign e_live  = rd_data[1];
    assign e_chk   = rd_data[0];
    assign wr_data = {wr_start, wr_len, wr_live, wr_chk};

    hcsm_table #(
        .DEPTH (MAX_CHUNKS),
        .WIDTH (ENT_W),
        .IDX_W (IDX_W)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (wr_idx),
        .i_wdata (wr_data),
        .i_re    (rd_en),
        .i_raddr (rd_idx),
        .o_rdata (rd_data)
    );

    hcsm_match #(
        .ADDR_BITS (ADDR_BITS)
    ) u_match (
        .i_addr   (r_addr),
        .i_base   (e_start),
        .i_len    (e_len),
        .i_margin (r_margin),
        .o_match  (mt)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_watch_lo <= '0;
            r_watch_hi <= '0;
            r_margin   <= MARGIN_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_WATCH_LOW: begin
                    r_watch_lo <= i_cfg_data;
                end
                CFG_WATCH_HIGH: begin
                    r_watch_hi <= i_cfg_data;
                end
                CFG_MARGIN: begin
                    r_margin <= i_cfg_data[MARGIN_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_action  <= i_in.action;
            r_addr    <= i_in.address;
            r_size    <= i_in.size;
            r_watched <= (i_in.pc >= r_watch_lo) && (i_in.pc <= r_watch_hi);
        end
    end

    always_comb begin
        walk_emit      = 1'b0;
        walk_rpt       = RPT_NONE;
        walk_wr        = 1'b0;
        walk_len       = e_len;
        walk_live      = e_live;
        walk_chk       = e_chk;
        walk_brk       = 1'b0;
        walk_hit       = 1'b0;
        walk_fault     = 1'b0;
        walk_fault_rpt = e_live ? RPT_UNCHECKED : RPT_UAF;
        case (r_action)
            ACT_ALLOC: begin
                if (mt.eq) begin
                    walk_wr   = 1'b1;
                    walk_len  = r_size;
                    walk_live = 1'b1;
                    walk_chk  = 1'b0;
                    walk_brk  = 1'b1;
                    walk_hit  = 1'b1;
                end
            end
            ACT_FREE: begin
                if (mt.eq) begin
                    walk_emit = !e_live;
                    walk_rpt  = RPT_DOUBLE_FREE;
                    walk_wr   = 1'b1;
                    walk_live = 1'b0;
                    walk_chk  = 1'b0;
                    walk_brk  = 1'b1;
                end
            end
            ACT_CHECK: begin
                if (mt.covered) begin
                    walk_wr  = 1'b1;
                    walk_chk = 1'b1;
                    walk_brk = 1'b1;
                end
            end
            ACT_ACCESS: begin
                if (mt.redzone) begin
                    walk_emit = 1'b1;
                    walk_rpt  = RPT_OOB;
                end
                if (mt.covered && !r_found) begin
                    walk_wr    = 1'b1;
                    walk_chk   = 1'b1;
                    walk_hit   = 1'b1;
                    walk_fault = r_watched && (!e_live || !e_chk);
                end
            end
            ACT_LEAK: begin
                walk_emit = e_live;
                walk_rpt  = e_chk ? RPT_LEAK : RPT_LEAK_UNCHECKED;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        n_state      = r_state;
        n_idx        = r_idx;
        n_count      = r_count;
        n_found      = r_found;
        n_fault_v    = r_fault_v;
        n_fault_rpt  = r_fault_rpt;
        n_fault_base = r_fault_base;
        n_pend_v     = r_pend_v;
        n_pend_rpt   = r_pend_rpt;
        n_pend_base  = r_pend_base;
        rd_en        = 1'b0;
        rd_idx       = r_idx;
        wr_en        = 1'b0;
        wr_idx       = r_idx;
        wr_start     = e_start;
        wr_len       = walk_len;
        wr_live      = walk_live;
        wr_chk       = walk_chk;
        emit_req     = 1'b0;
        emit_rpt     = RPT_NONE;
        emit_base    = '0;
        flush        = 1'b0;

        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    n_found   = 1'b0;
                    n_fault_v = 1'b0;
                    if ((i_in.action == ACT_ALLOC) && (i_in.size == '0)) begin
                        n_state = ST_ZERO;
                    end else begin
                        n_state = ST_PRE;
                    end
                end
            end
            ST_ZERO: begin
                emit_req  = 1'b1;
                emit_rpt  = RPT_ZERO_SIZE;
                emit_base = r_addr;
                if (can_emit) begin
                    n_state = ST_PRE;
                end
            end
            ST_PRE: begin
                if ((r_action == ACT_ALLOC) && (r_addr == '0)) begin
                    emit_req = 1'b1;
                    emit_rpt = RPT_ALLOC_NULL;
                    if (can_emit) begin
                        n_state = ST_FLUSH;
                    end
                end else if (!(r_action inside {[ACT_ALLOC:ACT_LEAK]})) begin
                    n_state = ST_FLUSH;
                end else if (r_count == '0) begin
                    n_state = ST_TAIL;
                end else begin
                    rd_en   = 1'b1;
                    rd_idx  = cnt_m1[IDX_W-1:0];
                    n_idx   = rd_idx;
                    n_state = ST_WALK;
                end
            end
            ST_WALK: begin
                emit_req  = walk_emit;
                emit_rpt  = walk_rpt;
                emit_base = e_start;
                if (!walk_emit || can_emit) begin
                    wr_en = walk_wr;
                    if (walk_hit) begin
                        n_found = 1'b1;
                    end
                    if (walk_fault) begin
                        n_fault_v    = 1'b1;
                        n_fault_rpt  = walk_fault_rpt;
                        n_fault_base = e_start;
                    end
                    if (walk_brk || (r_idx == '0)) begin
                        n_state = ST_TAIL;
                    end else begin
                        rd_en  = 1'b1;
                        rd_idx = r_idx - 1'b1;
                        n_idx  = rd_idx;
                    end
                end
            end
            ST_TAIL: begin
                if ((r_action == ACT_ALLOC) && !r_found) begin
                    if (r_count == CNT_MAX) begin
                        emit_req  = 1'b1;
                        emit_rpt  = RPT_TABLE_FULL;
                        emit_base = r_addr;
                        if (can_emit) begin
                            n_state = ST_FLUSH;
                        end
                    end else begin
                        wr_en    = 1'b1;
                        wr_idx   = r_count[IDX_W-1:0];
                        wr_start = r_addr;
                        wr_len   = r_size;
                        wr_live  = 1'b1;
                        wr_chk   = 1'b0;
                        n_count  = r_count + 1'b1;
                        n_state  = ST_FLUSH;
                    end
                end else if ((r_action == ACT_ACCESS) && r_fault_v) begin
                    emit_req  = 1'b1;
                    emit_rpt  = r_fault_rpt;
                    emit_base = r_fault_base;
                    if (can_emit) begin
                        n_state = ST_FLUSH;
                    end
                end else begin
                    n_state = ST_FLUSH;
                end
            end
            ST_FLUSH: begin
                flush = 1'b1;
                if (out_free) begin
                    n_pend_v = 1'b0;
                    n_state  = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        push      = 1'b0;
        push_rpt  = r_pend_rpt;
        push_base = r_pend_base;
        push_last = 1'b0;
        if (emit_req && can_emit) begin
            push        = r_pend_v;
            n_pend_v    = 1'b1;
            n_pend_rpt  = emit_rpt;
            n_pend_base = emit_base;
        end
        if (flush && out_free) begin
            push      = 1'b1;
            push_last = 1'b1;
            if (!r_pend_v) begin
                push_rpt  = RPT_NONE;
                push_base = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_count   <= '0;
            r_pend_v  <= 1'b0;
            r_fault_v <= 1'b0;
            r_found   <= 1'b0;
            r_idx     <= '0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_pend_v  <= n_pend_v;
            r_fault_v <= n_fault_v;
            r_found   <= n_found;
            r_idx     <= n_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        r_fault_rpt  <= n_fault_rpt;
        r_fault_base <= n_fault_base;
        r_pend_rpt   <= n_pend_rpt;
        r_pend_base  <= n_pend_base;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (push) begin
            r_out_v <= 1'b1;
        end else if (o_out.ready) begin
            r_out_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_out_rpt  <= push_rpt;
            r_out_base <= push_base;
            r_out_last <= push_last;
        end
    end

    `HCSM_ASSERT_SAME(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CNT_MAX,
                      "chunk count above table depth")
    `HCSM_ASSERT_SAME(a_count_step, i_clk, i_rst_n, $past(i_rst_n),
                      (r_count == $past(r_count)) || (r_count == $past(r_count) + 1'b1),
                      "chunk count moved by more than one")
    `HCSM_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, in_acc, r_state != ST_IDLE,
                      "sequencer idle after accepting a word")
    `HCSM_ASSERT_SAME(a_idle_no_pending, i_clk, i_rst_n, r_state == ST_IDLE, !r_pend_v,
                      "report left pending at idle")

endmodule
